@@ hw/rtl/xbrd_pkg.sv @@
// Package for the bounded xorshift random delay block.
// Holds widths, register indexes, sequencer states, the divider status
// struct and the generator step function. No dependencies.
package xbrd_pkg;

  localparam int BOUND_W = 16;
  localparam int SPAN_W  = 17;
  localparam int STATE_W = 32;
  localparam int CFG_IDX_W = 2;

  localparam int SHIFT_A = 13;
  localparam int SHIFT_B = 17;
  localparam int SHIFT_C = 5;

  localparam logic [STATE_W-1:0] GEN_RESET = 32'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOWER = 2'd0,
    REG_UPPER = 2'd1,
    REG_SEED  = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_FINISH
  } seq_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rem_status_t;

  function automatic logic [STATE_W-1:0] xorshift_step(input logic [STATE_W-1:0] x);
    logic [STATE_W-1:0] a;
    logic [STATE_W-1:0] b;
    logic [STATE_W-1:0] c;
    a = x ^ (x << SHIFT_A);
    b = a ^ (a >> SHIFT_B);
    c = b ^ (b << SHIFT_C);
    return c;
  endfunction

endpackage

@@ hw/rtl/xbrd_rem.sv @@
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// Depends on xbrd_pkg for widths and the status struct.
module xbrd_rem
  import xbrd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [STATE_W-1:0]  dividend,
  input  logic [SPAN_W-1:0]   divisor,
  output rem_status_t         status,
  output logic [SPAN_W-1:0]   remainder
);

  localparam int CNT_W = $clog2(STATE_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STATE_W - 1);

  logic [STATE_W-1:0] dvd_r, dvd_nxt;
  logic [SPAN_W-1:0]  dsr_r, dsr_nxt;
  logic [SPAN_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [SPAN_W:0]    trial;
  logic [SPAN_W:0]    diff;

  assign trial = {rem_r, dvd_r[STATE_W-1]};
  assign diff  = trial - {1'b0, dsr_r};

  always_comb begin
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt  = dividend;
      dsr_nxt  = divisor;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = dvd_r << 1;
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = diff[SPAN_W-1:0];
      end else begin
        rem_nxt = trial[SPAN_W-1:0];
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
  end

  assign status.busy = busy_r;
  assign status.done = done_r;
  assign remainder   = rem_r;

endmodule

@@ hw/rtl/xorshift_bounded_random_delay.sv @@
// Top level of the bounded xorshift random delay block: configuration
// registers, sequencer, generator state and output register.
// Depends on xbrd_pkg and xbrd_rem.
//
// Each request transfers one restart bit in and yields one value in
// [lower_bound, upper_bound]. With a valid range, the generator steps and
// the remainder unit loads at the transfer edge. The bit-serial remainder
// then works through the dividend, one dividend bit per cycle. The result
// register then takes the sum with the lower bound, and the output
// register loads from it. in_stall drops in the cycle after that load, so
// the next request is taken only once the result is in the output register.
// A range with upper_bound not above lower_bound answers with lower_bound
// and skips the remainder unit. in_stall stays high while a request
// is in work. A finished result waits in the output register while the
// next request is taken. The sequencer holds the result while the output
// register is full and stalled.
module xorshift_bounded_random_delay
  import xbrd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [STATE_W-1:0]   cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_restart,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [BOUND_W-1:0]   out_drawn_value
);

  seq_state_t          state_r, state_nxt;
  logic [BOUND_W-1:0]  lower_r, upper_r;
  logic [STATE_W-1:0]  seed_r;
  logic [STATE_W-1:0]  gen_r, gen_nxt;
  logic [BOUND_W-1:0]  result_r, result_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [BOUND_W-1:0]  out_value_r, out_value_nxt;

  logic                in_xfer;
  logic                out_free;
  logic                range_empty;
  logic [SPAN_W-1:0]   span;
  logic [STATE_W-1:0]  start_state;
  logic [STATE_W-1:0]  stepped;
  logic                rem_start;
  rem_status_t         rem_status;
  logic [SPAN_W-1:0]   rem_value;

  assign in_xfer     = in_valid && !in_stall;
  assign out_free    = !out_valid_r || !out_stall;
  assign range_empty = (upper_r <= lower_r);
  assign span        = {1'b0, upper_r} - {1'b0, lower_r} + SPAN_W'(1);
  assign start_state = in_restart ? ((seed_r == '0) ? GEN_RESET : seed_r) : gen_r;
  assign stepped     = xorshift_step(start_state);

  xbrd_rem u_rem (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (rem_start),
    .dividend  (stepped),
    .divisor   (span),
    .status    (rem_status),
    .remainder (rem_value)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_r <= '0;
      upper_r <= '0;
      seed_r  <= GEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LOWER: lower_r <= cfg_data[BOUND_W-1:0];
        REG_UPPER: upper_r <= cfg_data[BOUND_W-1:0];
        REG_SEED:  seed_r  <= cfg_data;
        default:   ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = range_empty ? ST_FINISH : ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (rem_status.done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall      = (state_r != ST_IDLE);
    rem_start     = 1'b0;
    gen_nxt       = gen_r;
    result_nxt    = result_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_value_nxt = out_value_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (range_empty) begin
            gen_nxt    = start_state;
            result_nxt = lower_r;
          end else begin
            gen_nxt   = stepped;
            rem_start = 1'b1;
          end
        end
      end
      ST_DIVIDE: begin
        if (rem_status.done) begin
          result_nxt = lower_r + rem_value[BOUND_W-1:0];
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = result_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      gen_r       <= GEN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      gen_r       <= gen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    result_r    <= result_nxt;
    out_value_r <= out_value_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_drawn_value = out_value_r;

  a_gen_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    gen_r != '0)
    else $error("generator state reached zero");

  a_done_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
    rem_status.done |-> (state_r == ST_DIVIDE))
    else $error("remainder finished outside the divide phase");

  a_rem_below_span: assert property (@(posedge clk) disable iff (!rst_n)
    rem_status.done |-> (rem_value < span))
    else $error("remainder not below span");

  a_empty_range: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && range_empty) |=> (state_r == ST_FINISH) && (result_r == $past(lower_r)))
    else $error("empty range did not return lower bound");

endmodule

@@ dv/testbench.sv @@
// Testbench for the bounded xorshift random delay block: draws checked against an
// in-bench generator model across bound, seed and flow-control settings.
// Depends on xbrd_pkg and xorshift_bounded_random_delay.
module testbench;
  import xbrd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT = 600000;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 160;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_LOWER;
  logic [STATE_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_restart = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [BOUND_W-1:0] out_drawn_value;

  logic [BOUND_W-1:0] bound_lo = '0;
  logic [BOUND_W-1:0] bound_hi = '0;
  logic [STATE_W-1:0] seed_reg = GEN_RESET;
  logic [STATE_W-1:0] gen_state = GEN_RESET;

  logic restart_q[$];
  logic [BOUND_W-1:0] drawn_q[$];
  idle_mode_t idle_mode = IDLE_NONE;
  logic in_taken = 1'b0;
  logic hold = 1'b0;
  int n_taken = 0;
  int n_err = 0;
  int cycles = 0;

  xorshift_bounded_random_delay u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_restart      (in_restart),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_drawn_value (out_drawn_value)
  );

  always #5 clk = ~clk;

  function automatic logic [BOUND_W-1:0] predict_draw(input logic restart);
    logic [STATE_W-1:0] x;
    logic [STATE_W-1:0] span;
    logic [STATE_W-1:0] rem;
    if (restart) begin
      gen_state = (seed_reg == '0) ? GEN_RESET : seed_reg;
    end
    if (bound_hi <= bound_lo) begin
      return bound_lo;
    end
    span = {16'b0, bound_hi} - {16'b0, bound_lo} + 32'd1;
    x = gen_state;
    x = x ^ (x << SHIFT_A);
    x = x ^ (x >> SHIFT_B);
    x = x ^ (x << SHIFT_C);
    gen_state = x;
    rem = x % span;
    return bound_lo + rem[BOUND_W-1:0];
  endfunction

  function automatic logic sender_idle();
    case (idle_mode)
      IDLE_SEND: return $urandom_range(99) < 87;
      IDLE_BOTH: return $urandom_range(99) < 30;
      default:   return 1'b0;
    endcase
  endfunction

  function automatic logic receiver_stall();
    case (idle_mode)
      IDLE_RECV: return $urandom_range(99) < 87;
      IDLE_BOTH: return $urandom_range(99) < 30;
      default:   return 1'b0;
    endcase
  endfunction

  task automatic report(input string what, input logic [BOUND_W-1:0] got,
                        input logic [BOUND_W-1:0] want);
    $display("mismatch at cycle %0d: %s got %h want %h", cycles, what, got, want);
    n_err++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [STATE_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_LOWER: bound_lo = data[BOUND_W-1:0];
      REG_UPPER: bound_hi = data[BOUND_W-1:0];
      REG_SEED:  seed_reg = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (restart_q.size() != 0 || in_valid || drawn_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_config();
    logic [BOUND_W-1:0] lo;
    logic [BOUND_W-1:0] hi;
    lo = BOUND_W'($urandom);
    hi = BOUND_W'($urandom);
    case ($urandom_range(5))
      0: begin lo = '0; hi = '1; end
      1: hi = lo + BOUND_W'($urandom_range(255));
      2: ;
      3: hi = lo - BOUND_W'($urandom_range(3));
      4: begin lo = 16'hFFFE; hi = '1; end
      default: begin lo = '0; hi = BOUND_W'($urandom_range(1, 15)); end
    endcase
    write_reg(REG_LOWER, {16'($urandom_range(16'hFFFF)), lo});
    write_reg(REG_UPPER, {16'($urandom_range(16'hFFFF)), hi});
    case ($urandom_range(7))
      0: write_reg(REG_SEED, '0);
      1: write_reg(REG_SEED, '1);
      default: write_reg(REG_SEED, $urandom);
    endcase
  endtask

  // transfer bookkeeping and result check
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (drawn_q.size() == 0) begin
        report("unexpected drawn_value", out_drawn_value, '0);
      end else if (out_drawn_value !== drawn_q[0]) begin
        report("drawn_value", out_drawn_value, drawn_q.pop_front());
      end else begin
        void'(drawn_q.pop_front());
      end
    end
    in_taken = rst_n && in_valid && !in_stall;
    if (in_taken) begin
      drawn_q.push_back(predict_draw(in_restart));
      n_taken++;
      if ($urandom_range(39) == 0 || n_taken == 5) hold = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (hold && drawn_q.size() == 0) hold = 1'b0;
      if (restart_q.size() != 0 && !hold && !sender_idle()) begin
        in_valid <= 1'b1;
        in_restart <= restart_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= rst_n && receiver_stall();
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // bounds at reset are empty: draws return the lower bound
    restart_q.push_back(1'b0);
    restart_q.push_back(1'b1);
    drain();

    // full range, zero seed
    write_reg(REG_LOWER, 32'hFFFF_0000);
    write_reg(REG_UPPER, 32'hABCD_FFFF);
    write_reg(REG_SEED, '0);
    restart_q.push_back(1'b1);
    restart_q.push_back(1'b0);
    restart_q.push_back(1'b0);
    restart_q.push_back(1'b0);
    drain();

    // equal bounds at the top, restart still reloads
    write_reg(REG_SEED, '1);
    write_reg(REG_LOWER, 32'h1234_FFFF);
    restart_q.push_back(1'b0);
    restart_q.push_back(1'b1);
    drain();

    // inverted bounds
    write_reg(REG_UPPER, 32'hFFFF_0000);
    restart_q.push_back(1'b1);
    restart_q.push_back(1'b0);
    drain();

    // two-value range, write to an unused index
    write_reg(REG_LOWER, 32'd5);
    write_reg(REG_UPPER, 32'd6);
    write_reg(REG_SPARE, '1);
    restart_q.push_back(1'b0);
    restart_q.push_back(1'b0);
    restart_q.push_back(1'b1);
    restart_q.push_back(1'b0);
    drain();

    write_reg(REG_LOWER, 32'h0000_8000);
    write_reg(REG_UPPER, 32'h0000_FFFF);
    restart_q.push_back(1'b0);
    restart_q.push_back(1'b0);
    drain();

    for (int p = 0; p < RAND_PHASES; p++) begin
      random_config();
      idle_mode = idle_mode_t'(p % 4);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        restart_q.push_back($urandom_range(7) == 0);
      end
      drain();
    end

    if (n_err == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/xbrd_pkg.sv
hw/rtl/xbrd_rem.sv
hw/rtl/xorshift_bounded_random_delay.sv
dv/testbench.sv
